FILE: rtl/sfpf_pkg.sv
// ----------------------------------------------------------------------------
// Sync frame parser package
// Shared types and constants of the sync-framed Fletcher deframer.
// ----------------------------------------------------------------------------
package sfpf_pkg;

  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [7:0] SyncFirstReset  = 8'd147;
  localparam logic [7:0] SyncSecondReset = 8'd224;

  localparam logic CfgIdxSyncFirst  = 1'b0;
  localparam logic CfgIdxSyncSecond = 1'b1;

  typedef enum logic [6:0] {
    PhHunt    = 7'b000_0001,
    PhSync2   = 7'b000_0010,
    PhId      = 7'b000_0100,
    PhLength  = 7'b000_1000,
    PhPayload = 7'b001_0000,
    PhCkLow   = 7'b010_0000,
    PhCkHigh  = 7'b100_0000
  } phase_e;

  typedef enum logic [1:0] {
    KindPayload  = 2'd0,
    KindGood     = 2'd1,
    KindBadCheck = 2'd2,
    KindSyncErr  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [15:0] error_total;
    logic [7:0]  byte_index;
    logic [7:0]  frame_length;
    logic [7:0]  frame_id;
    logic [7:0]  data_byte;
    kind_e       kind;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

FILE: rtl/sync_frame_parser_fletcher_unit.sv
// ----------------------------------------------------------------------------
// Sync frame parser with Fletcher checksum
// Deframes a received byte stream and reports payload bytes and verdicts.
// ----------------------------------------------------------------------------
// One received byte is taken per clock cycle whenever the result queue has
// room; the parser finishes each byte in the cycle it is accepted, so the
// sustained rate is one byte per cycle. A transaction caused by a byte is
// written into the result queue and then into the output register before it
// appears on the master side, and up to the queue depth plus one results can
// wait for the downstream side before the slave side stalls. The sync values
// are written through the configuration channel, which is always ready.
module sync_frame_parser_fletcher_unit import sfpf_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // [7:0] data_byte, [15:8] frame_id,
                                        // [23:16] frame_length, [31:24] byte_index,
                                        // [47:32] error_total
  output logic [1:0]  m_axis_tuser_o,   // [1:0] kind
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  queue_status_t q_status;
  logic          push;
  logic          pop;
  result_t       push_data;
  result_t       pop_data;

  sfpf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_valid_i      (s_axis_tvalid_i),
    .s_ready_o      (s_axis_tready_o),
    .rx_byte_i      (s_axis_tdata_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .queue_status_i (q_status),
    .push_o         (push),
    .push_data_o    (push_data)
  );

  sfpf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  sfpf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .queue_status_i (q_status),
    .queue_data_i   (pop_data),
    .pop_o          (pop),
    .m_valid_o      (m_axis_tvalid_o),
    .m_ready_i      (m_axis_tready_i),
    .m_data_o       (m_axis_tdata_o),
    .m_user_o       (m_axis_tuser_o)
  );

endmodule

FILE: rtl/sfpf_front.sv
// ----------------------------------------------------------------------------
// Sync frame parser front end
// Accepts received bytes, tracks the frame phase and checksum, and queues
// the resulting transactions.
// ----------------------------------------------------------------------------
module sfpf_front import sfpf_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  output logic          s_ready_o,
  input  logic [7:0]    rx_byte_i,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic          cfg_index_i,
  input  logic [7:0]    cfg_data_i,
  input  queue_status_t queue_status_i,
  output logic          push_o,
  output result_t       push_data_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  sync_first_q, sync_second_q;
  logic [7:0]  held_id_q, held_id_d;
  logic [7:0]  held_len_q, held_len_d;
  logic [7:0]  seen_q, seen_d;
  logic [7:0]  sum_lo_q, sum_lo_d;
  logic [7:0]  sum_hi_q, sum_hi_d;
  logic [7:0]  ck_lo_q, ck_lo_d;
  logic [15:0] err_q, err_d;
  logic        accept;
  logic        emit;
  logic        count_err;
  logic        good;
  logic [7:0]  lo_plus;
  logic [7:0]  seen_inc;

  assign s_ready_o   = ~queue_status_i.full;
  assign cfg_ready_o = 1'b1;
  assign accept      = s_valid_i & s_ready_o;
  assign lo_plus     = sum_lo_q + rx_byte_i;
  assign seen_inc    = seen_q + 8'd1;
  assign good        = (ck_lo_q == sum_lo_q) && (rx_byte_i == sum_hi_q);

  always_comb begin
    phase_d     = phase_q;
    held_id_d   = held_id_q;
    held_len_d  = held_len_q;
    seen_d      = seen_q;
    sum_lo_d    = sum_lo_q;
    sum_hi_d    = sum_hi_q;
    ck_lo_d     = ck_lo_q;
    emit        = 1'b0;
    count_err   = 1'b0;
    push_data_o = '0;
    unique case (phase_q)
      PhHunt: begin
        if (rx_byte_i == sync_first_q) phase_d = PhSync2;
      end
      PhSync2: begin
        if (rx_byte_i == sync_second_q) begin
          phase_d = PhId;
        end else if (rx_byte_i != sync_first_q) begin
          phase_d          = PhHunt;
          count_err        = 1'b1;
          emit             = 1'b1;
          push_data_o.kind = KindSyncErr;
        end
      end
      PhId: begin
        held_id_d = rx_byte_i;
        sum_lo_d  = rx_byte_i;
        sum_hi_d  = rx_byte_i;
        phase_d   = PhLength;
      end
      PhLength: begin
        held_len_d = rx_byte_i;
        sum_lo_d   = lo_plus;
        sum_hi_d   = sum_hi_q + lo_plus;
        seen_d     = '0;
        phase_d    = (rx_byte_i == 8'd0) ? PhCkLow : PhPayload;
      end
      PhPayload: begin
        sum_lo_d                 = lo_plus;
        sum_hi_d                 = sum_hi_q + lo_plus;
        seen_d                   = seen_inc;
        if (seen_inc == held_len_q) phase_d = PhCkLow;
        emit                     = 1'b1;
        push_data_o.kind         = KindPayload;
        push_data_o.data_byte    = rx_byte_i;
        push_data_o.frame_id     = held_id_q;
        push_data_o.frame_length = held_len_q;
        push_data_o.byte_index   = seen_q;
      end
      PhCkLow: begin
        ck_lo_d = rx_byte_i;
        phase_d = PhCkHigh;
      end
      PhCkHigh: begin
        count_err                = ~good;
        phase_d                  = PhHunt;
        emit                     = 1'b1;
        push_data_o.kind         = good ? KindGood : KindBadCheck;
        push_data_o.frame_id     = held_id_q;
        push_data_o.frame_length = held_len_q;
      end
      default: begin
        phase_d = PhHunt;
      end
    endcase
    err_d = (count_err && (err_q != 16'hFFFF)) ? err_q + 16'd1 : err_q;
    push_data_o.error_total = err_d;
  end

  assign push_o = accept & emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhHunt;
      sync_first_q  <= SyncFirstReset;
      sync_second_q <= SyncSecondReset;
      held_id_q     <= '0;
      held_len_q    <= '0;
      seen_q        <= '0;
      sum_lo_q      <= '0;
      sum_hi_q      <= '0;
      ck_lo_q       <= '0;
      err_q         <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CfgIdxSyncFirst) sync_first_q <= cfg_data_i;
        if (cfg_index_i == CfgIdxSyncSecond) sync_second_q <= cfg_data_i;
      end
      if (accept) begin
        phase_q    <= phase_d;
        held_id_q  <= held_id_d;
        held_len_q <= held_len_d;
        seen_q     <= seen_d;
        sum_lo_q   <= sum_lo_d;
        sum_hi_q   <= sum_hi_d;
        ck_lo_q    <= ck_lo_d;
        err_q      <= err_d;
      end
    end
  end

  a_err_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (err_q >= $past(err_q)))
    else $error("error counter decreased");

  a_payload_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && (push_data_o.kind == KindPayload)) |-> (phase_q == PhPayload))
    else $error("payload transaction outside the payload phase");

endmodule

FILE: rtl/sfpf_queue.sv
// ----------------------------------------------------------------------------
// Sync frame parser result queue
// Small first-in first-out queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module sfpf_queue import sfpf_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  result_t       push_data_i,
  input  logic          pop_i,
  output result_t       pop_data_o,
  output queue_status_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  result_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign status_o.full  = (count_q == FullCnt);
  assign status_o.empty = (count_q == '0);
  assign pop_data_o     = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      if (pop_i) rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty)
    else $error("pop from an empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("queue count beyond its depth");

endmodule

FILE: rtl/sfpf_back.sv
// ----------------------------------------------------------------------------
// Sync frame parser output stage
// Drains the result queue into a registered master-side stream.
// ----------------------------------------------------------------------------
module sfpf_back import sfpf_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  queue_status_t queue_status_i,
  input  result_t       queue_data_i,
  output logic          pop_o,
  output logic          m_valid_o,
  input  logic          m_ready_i,
  output logic [47:0]   m_data_o,
  output logic [1:0]    m_user_o
);

  logic    valid_q;
  result_t out_q;

  assign pop_o = ~queue_status_i.empty & (~valid_q | m_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (~valid_q | m_ready_i) begin
      valid_q <= ~queue_status_i.empty;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) out_q <= queue_data_i;
  end

  assign m_valid_o = valid_q;
  assign m_user_o  = out_q.kind;
  assign m_data_o  = {out_q.error_total, out_q.byte_index, out_q.frame_length,
                      out_q.frame_id, out_q.data_byte};

endmodule
